// ===== rtl/core/fpm_pkg.sv =====
`default_nettype none
package fpm_pkg;
	localparam int PROD_W  = 25;
	localparam int INDEX_W = 10;
	localparam int FIELD_W = 8;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_MERGE = 4'b1000
	} fpm_state_t;

	typedef struct packed {
		logic valid;
		logic first;
	} lane_ctl_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} merge_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/fpm_lane.sv =====
`default_nettype none
module fpm_lane #(
	parameter int LOG_MAX_POINTS = 10,
	parameter int CW             = 8,
	parameter int LANE           = 0
) (
	input  wire  logic                            clk,
	input  wire  logic                            arst_n,
	input  wire  logic                            b_wr_en,
	input  wire  logic [LOG_MAX_POINTS-1:0]       b_wr_addr,
	input  wire  logic [CW-1:0]                   b_wr_data,
	input  wire  logic [LOG_MAX_POINTS:0]         k0,
	input  wire  logic [LOG_MAX_POINTS:0]         idx_i,
	input  wire  logic [LOG_MAX_POINTS:0]         len_b,
	input  wire  fpm_pkg::lane_ctl_t              ctl,
	input  wire  logic [CW-1:0]                   a_s1,
	output logic [2*CW+LOG_MAX_POINTS-1:0]        acc
);
	import fpm_pkg::*;
	localparam int PW    = LOG_MAX_POINTS + 1;
	localparam int ACC_W = 2*CW + LOG_MAX_POINTS;
	localparam int DEPTH = 1 << LOG_MAX_POINTS;

	logic [CW-1:0]    b_mem [DEPTH];
	logic [CW-1:0]    b_s1;
	logic             ok_s1;
	lane_ctl_t        ctl_s1, ctl_s2;
	logic [2*CW-1:0]  prod_s2;
	logic [ACC_W-1:0] acc_q;
	logic [PW:0]      tgt;
	logic [PW:0]      jdiff;
	logic             ok;

	// this lane works on output coefficient k0 + LANE
	assign tgt   = {1'b0, k0} + (PW+1)'(LANE);
	assign jdiff = tgt - {1'b0, idx_i};
	assign ok    = (tgt >= {1'b0, idx_i}) && (jdiff < {1'b0, len_b});

	always_ff @(posedge clk) begin
		if (b_wr_en) begin
			b_mem[b_wr_addr] <= b_wr_data;
		end
		b_s1    <= b_mem[jdiff[LOG_MAX_POINTS-1:0]];
		ok_s1   <= ok;
		prod_s2 <= ok_s1 ? (2*CW)'(a_s1) * (2*CW)'(b_s1) : '0;
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

// ===== rtl/core/fpm_merge.sv =====
`default_nettype none
module fpm_merge #(
	parameter int LOG_MAX_POINTS = 10,
	parameter int ACC_W          = 26,
	parameter int NUM_LANES      = 4,
	parameter int LW             = 2
) (
	input  wire  logic                                clk,
	input  wire  fpm_pkg::merge_ctl_t                 ctl,
	input  wire  logic [NUM_LANES-1:0][ACC_W-1:0]     lane_acc,
	input  wire  logic [LW-1:0]                       sel,
	input  wire  logic [LOG_MAX_POINTS-1:0]           wr_addr,
	input  wire  logic [LOG_MAX_POINTS-1:0]           rd_addr,
	output logic [fpm_pkg::PROD_W-1:0]                rd_data
);
	import fpm_pkg::*;
	localparam int SW    = (ACC_W < PROD_W) ? ACC_W : PROD_W;
	localparam int DEPTH = 1 << LOG_MAX_POINTS;

	logic [SW-1:0] res_mem [DEPTH];
	logic [SW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			res_mem[wr_addr] <= lane_acc[sel][SW-1:0];
		end
		if (ctl.rd_en) begin
			rd_q <= res_mem[rd_addr];
		end
	end

	assign rd_data = PROD_W'(rd_q);
endmodule
`default_nettype wire

// ===== rtl/core/fft_polynomial_multiply.sv =====
// a load item is taken in ST_IDLE; the closing load starts the product, formed in
//   ceil(n/NUM_LANES) blocks, each passing ST_RUN, ST_DRAIN and ST_MERGE, n = la + lb - 1
// throughput: one a coefficient per cycle per lane in ST_RUN, NUM_LANES outputs in step
// a fetch item gives its result the next cycle; one item in flight at a time
// arst_n clears lengths, positions and the pending flag; the stores are not cleared
`default_nettype none
module fft_polynomial_multiply #(
	parameter int LOG_MAX_POINTS = 10,
	parameter int COEF_BITS      = 8,
	parameter int NUM_LANES      = 4
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	// coef_a, a_present, coef_b, b_present, zero fill
	input  wire  logic [23:0] s_axis_tdata,
	// req_type
	input  wire  logic        s_axis_tuser,
	input  wire  logic        s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	// product_coef, coef_index, zero fill
	output logic [39:0]       m_axis_tdata,
	output logic              m_axis_tlast
);
	import fpm_pkg::*;
	localparam int CW    = (COEF_BITS < FIELD_W) ? COEF_BITS : FIELD_W;
	localparam int PW    = LOG_MAX_POINTS + 1;
	localparam int ACC_W = 2*CW + LOG_MAX_POINTS;
	localparam int LW    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int DEPTH = 1 << LOG_MAX_POINTS;
	localparam logic [PW-1:0] MAXP = PW'(DEPTH);
	localparam logic [PW-1:0] NL   = PW'(NUM_LANES);

	fpm_state_t       state_q;
	logic [PW-1:0]    len_a_q, len_b_q, load_pos_q;
	logic [PW-1:0]    la_q, lb_q, need_q, count_q, fetch_pos_q;
	logic [PW-1:0]    k0_q, i_q;
	logic [1:0]       drain_q;
	logic [LW-1:0]    m_q;
	logic             pending_q;
	logic             out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic             out_last_q;

	logic [CW-1:0]    a_mem [DEPTH];
	logic [CW-1:0]    a_s1;

	logic             acc_in, is_load, is_fetch;
	logic [CW-1:0]    ca, cb;
	logic             ap, bp;
	logic             acc_a, acc_b, in_range;
	logic [PW-1:0]    la_new, lb_new;
	logic [PW:0]      cap_a, cap_b;
	logic [PW:0]      need_full;
	logic [CW-1:0]    va, vb;
	logic [PW:0]      merge_k;
	logic             merge_ok;
	logic             fetch_hit;
	lane_ctl_t        lctl;
	merge_ctl_t       mctl;
	logic [NUM_LANES-1:0][ACC_W-1:0] lane_acc;
	logic [PROD_W-1:0] rd_data;

	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign acc_in   = s_axis_tvalid && s_axis_tready;
	assign is_load  = acc_in && !s_axis_tuser;
	assign is_fetch = acc_in && s_axis_tuser;

	assign ca = s_axis_tdata[CW-1:0];
	assign ap = s_axis_tdata[8];
	assign cb = s_axis_tdata[9 +: CW];
	assign bp = s_axis_tdata[17];

	assign in_range = load_pos_q < MAXP;
	// an empty side counts as one in the capacity check; b sees the updated a length
	assign cap_a = {1'b0, len_a_q} + (PW+1)'(1)
		+ ((len_b_q != '0) ? {1'b0, len_b_q} : (PW+1)'(1));
	assign acc_a  = in_range && ap && (load_pos_q == len_a_q)
		&& (cap_a <= {1'b0, MAXP} + (PW+1)'(1));
	assign la_new = acc_a ? len_a_q + PW'(1) : len_a_q;
	assign cap_b = {1'b0, len_b_q} + (PW+1)'(1)
		+ ((la_new != '0) ? {1'b0, la_new} : (PW+1)'(1));
	assign acc_b  = in_range && bp && (load_pos_q == len_b_q)
		&& (cap_b <= {1'b0, MAXP} + (PW+1)'(1));
	assign lb_new = acc_b ? len_b_q + PW'(1) : len_b_q;
	assign va = acc_a ? ca : '0;
	assign vb = acc_b ? cb : '0;
	assign need_full = {1'b0, la_new} + {1'b0, lb_new} - (PW+1)'(1);

	assign merge_k  = {1'b0, k0_q} + (PW+1)'(m_q);
	assign merge_ok = merge_k < {1'b0, need_q};
	assign fetch_hit = pending_q && (fetch_pos_q < count_q);

	assign lctl.valid = (state_q == ST_RUN);
	assign lctl.first = (i_q == '0);
	assign mctl.wr_en = (state_q == ST_MERGE) && merge_ok;
	assign mctl.rd_en = is_fetch && fetch_hit;

	always_ff @(posedge clk) begin
		if (is_load && in_range) begin
			a_mem[load_pos_q[LOG_MAX_POINTS-1:0]] <= va;
		end
		a_s1 <= a_mem[i_q[LOG_MAX_POINTS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_a_q     <= '0;
			len_b_q     <= '0;
			load_pos_q  <= '0;
			la_q        <= '0;
			lb_q        <= '0;
			need_q      <= '0;
			count_q     <= '0;
			fetch_pos_q <= '0;
			k0_q        <= '0;
			i_q         <= '0;
			drain_q     <= '0;
			m_q         <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						pending_q <= 1'b0;
						if (s_axis_tlast) begin
							len_a_q    <= '0;
							len_b_q    <= '0;
							load_pos_q <= '0;
							if (la_new != '0 && lb_new != '0) begin
								la_q   <= la_new;
								lb_q   <= lb_new;
								need_q <= (need_full > {1'b0, MAXP}) ? MAXP
									: need_full[PW-1:0];
								k0_q   <= '0;
								i_q    <= '0;
								state_q <= ST_RUN;
							end
						end else begin
							len_a_q <= la_new;
							len_b_q <= lb_new;
							if (in_range) begin
								load_pos_q <= load_pos_q + PW'(1);
							end
						end
					end else if (is_fetch) begin
						if (fetch_hit) begin
							out_valid_q <= 1'b1;
							out_idx_q   <= fetch_pos_q[INDEX_W-1:0];
							out_last_q  <= (fetch_pos_q + PW'(1) == count_q);
							fetch_pos_q <= fetch_pos_q + PW'(1);
							if (fetch_pos_q + PW'(1) >= count_q) begin
								pending_q <= 1'b0;
							end
						end else begin
							pending_q <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					if (i_q + PW'(1) == la_q) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						i_q <= i_q + PW'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						m_q     <= '0;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					m_q <= m_q + LW'(1);
					if (m_q == LW'(NUM_LANES - 1)) begin
						if ({1'b0, k0_q} + {1'b0, NL} >= {1'b0, need_q}) begin
							count_q     <= need_q;
							fetch_pos_q <= '0;
							pending_q   <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							k0_q    <= k0_q + NL;
							i_q     <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		fpm_lane #(
			.LOG_MAX_POINTS(LOG_MAX_POINTS),
			.CW(CW),
			.LANE(l)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.b_wr_en(is_load && in_range),
			.b_wr_addr(load_pos_q[LOG_MAX_POINTS-1:0]),
			.b_wr_data(vb),
			.k0(k0_q),
			.idx_i(i_q),
			.len_b(lb_q),
			.ctl(lctl),
			.a_s1(a_s1),
			.acc(lane_acc[l])
		);
	end

	fpm_merge #(
		.LOG_MAX_POINTS(LOG_MAX_POINTS),
		.ACC_W(ACC_W),
		.NUM_LANES(NUM_LANES),
		.LW(LW)
	) u_merge (
		.clk(clk),
		.ctl(mctl),
		.lane_acc(lane_acc),
		.sel(m_q),
		.wr_addr(merge_k[LOG_MAX_POINTS-1:0]),
		.rd_addr(fetch_pos_q[LOG_MAX_POINTS-1:0]),
		.rd_data(rd_data)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_idx_q, rd_data};
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input ready while product is being formed");
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (fetch_pos_q < count_q))
		else $error("pending flag set with no coefficient left");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (i_q < la_q))
		else $error("lane index ran past length of a");
	a_merge_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> (count_q != '0 && count_q <= MAXP))
		else $error("product count out of range");
`endif
endmodule
`default_nettype wire
